/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the filter core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define MADF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked property, checked during reset as well.
`define MADF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/madf_pkg.sv */
// ----------------------------------------------------------------------------
// madf_pkg
// Field widths, register codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package madf_pkg;

   localparam int CHAN_W     = 4;
   localparam int SAMPLE_W   = 12;
   localparam int WIN_W      = 8;
   localparam int HYST_W     = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [WIN_W-1:0]    WINDOW_RESET = 8'd8;
   localparam logic [HYST_W-1:0]   HYST_RESET   = 12'd4;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 12'hFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WINDOW_LENGTH = 1'b0,
      REG_HYSTERESIS    = 1'b1
   } csr_reg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;        // capture the accepted word
      logic prime_start;  // seed sum with sample * length
      logic fill;         // write one history slot while priming
      logic rd_issue;     // read the oldest history entry
      logic update;       // swap oldest entry, adjust running sum
      logic div_start;    // launch mean division
      logic compare;      // apply deadband to the mean
      logic out_load;     // load the result register
   } madf_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic ch_ok;
      logic need_prime;
      logic fill_last;
      logic div_done;
   } madf_stat_type;

endpackage

/* src/madf_if.sv */
// ----------------------------------------------------------------------------
// madf interfaces
// Sample, result and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface madf_req_if import madf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   channel;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, channel, sample, input ready);
   modport sink   (input valid, channel, sample, output ready);
endinterface

interface madf_rsp_if import madf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   channel_out;
   logic [SAMPLE_W-1:0] filtered;

   modport source (output valid, channel_out, filtered, input ready);
   modport sink   (input valid, channel_out, filtered, output ready);
endinterface

interface madf_csr_if import madf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/moving_average_deadband_filter_core.sv */
// ----------------------------------------------------------------------------
// moving_average_deadband_filter_core
// Per-channel moving average of converter samples with a deadband output.
// ----------------------------------------------------------------------------
//
//   port     dir  payload                         word
//   -------  ---  ------------------------------  ----------------------------
//   req_ch   in   channel[3:0], sample[11:0]      one raw sample
//   rsp_ch   out  channel_out[3:0], filtered[11:0] one held average per sample
//   csr_ch   in   index[0], data[11:0]            register write
//
// A priming word (first after reset or after a length change) fills the
// history RAM one slot per cycle. An update word waits on the bit-serial
// divider that forms the mean; a word on an absent channel is dropped.
// Reset is synchronous and needs no clearing pass; history is only read
// after priming has written it. A stalled result waits in the output
// register while the next word is taken and worked on.
// ----------------------------------------------------------------------------
module moving_average_deadband_filter_core import madf_pkg::*; #(
   parameter int HISTORY_DEPTH = 64,
   parameter int NUM_CHANNELS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   madf_csr_if.sink   csr_ch,
   madf_req_if.sink   req_ch,
   madf_rsp_if.source rsp_ch
);

   madf_cmd_type        cmd;
   madf_stat_type       stat;
   logic [WIN_W-1:0]    window_ff;
   logic [HYST_W-1:0]   hyst_ff;

   // Register writes land at once; the port never stalls
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         hyst_ff   <= HYST_RESET;
      end else if (csr_ch.valid) begin
         case (csr_reg_type'(csr_ch.index))
            REG_WINDOW_LENGTH: window_ff <= csr_ch.data[WIN_W-1:0];
            REG_HYSTERESIS:    hyst_ff   <= csr_ch.data[HYST_W-1:0];
            default:           ;
         endcase
      end
   end

   // Sequencer: one word in flight, hold results until taken
   madf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Filter state, history RAM, divider and deadband compare
   madf_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .NUM_CHANNELS  (NUM_CHANNELS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_channel   (req_ch.channel),
      .req_sample    (req_ch.sample),
      .window_length (window_ff),
      .hysteresis    (hyst_ff),
      .out_channel   (rsp_ch.channel_out),
      .out_filtered  (rsp_ch.filtered)
   );

endmodule

/* src/madf_ram.sv */
// ----------------------------------------------------------------------------
// madf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module madf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/madf_div.sv */
// ----------------------------------------------------------------------------
// madf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module madf_div #(
   parameter int DVD_W = 18,
   parameter int DVS_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVD_W-1:0] quo_ff;

   logic [DVS_W:0]   trial;
   logic             take;
   logic [DVS_W-1:0] rem_in;

   // Shift in the next dividend bit and subtract when it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      take   = (trial >= {1'b0, dvs_ff});
      rem_in = take ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvs_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DVD_W-2:0], take};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `MADF_ASSERT(a_div_done_pulse, clock, reset, done_ff |=> !done_ff, "divider done held")

endmodule

/* src/madf_datapath.sv */
// ----------------------------------------------------------------------------
// madf_datapath
// Per-channel filter state, history RAM, running sum, mean and deadband.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module madf_datapath import madf_pkg::*; #(
   parameter int HISTORY_DEPTH = 64,
   parameter int NUM_CHANNELS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  madf_cmd_type        cmd,
   output madf_stat_type       stat,
   input  logic [CHAN_W-1:0]   req_channel,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic [WIN_W-1:0]    window_length,
   input  logic [HYST_W-1:0]   hysteresis,
   output logic [CHAN_W-1:0]   out_channel,
   output logic [SAMPLE_W-1:0] out_filtered
);

   localparam int LEN_W     = $clog2(HISTORY_DEPTH + 1);
   localparam int IDX_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SUM_W     = SAMPLE_W + $clog2(HISTORY_DEPTH);
   localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int MEM_DEPTH = NUM_CHANNELS * HISTORY_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   // Per-channel filter state
   logic [SUM_W-1:0]    sum_ff    [NUM_CHANNELS];
   logic [IDX_W-1:0]    widx_ff   [NUM_CHANNELS];
   logic [SAMPLE_W-1:0] held_ff   [NUM_CHANNELS];
   logic                primed_ff [NUM_CHANNELS];
   logic [LEN_W-1:0]    lenu_ff   [NUM_CHANNELS];

   // Working registers for the word in flight
   logic [CHAN_W-1:0]   ch_ff;
   logic [SAMPLE_W-1:0] smp_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [IDX_W-1:0]    fill_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [SUM_W-1:0]    work_sum_ff;
   logic [CHAN_W-1:0]   out_ch_ff;
   logic [SAMPLE_W-1:0] out_filt_ff;

   logic [CH_IDX_W-1:0] chi;
   logic [LEN_W-1:0]    len_in;
   logic [IDX_W-1:0]    idx_cur;
   logic [LEN_W-1:0]    idx_inc;
   logic [IDX_W-1:0]    idx_in;
   logic [SUM_W-1:0]    sum_in;
   logic [SUM_W-1:0]    quotient;
   logic [SAMPLE_W-1:0] avg;
   logic [SAMPLE_W-1:0] diff;
   logic                div_done;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [SAMPLE_W-1:0] rd_data;

   function automatic logic [ADDR_W-1:0] mem_addr(input logic [CH_IDX_W-1:0] c,
                                                  input logic [IDX_W-1:0] i);
      return ADDR_W'(32'(c) * HISTORY_DEPTH + 32'(i));
   endfunction

   assign chi = CH_IDX_W'(ch_ff);

   // Clamp the window length to 1..HISTORY_DEPTH
   always_comb begin
      if (window_length == '0) begin
         len_in = LEN_W'(1);
      end else if (32'(window_length) > HISTORY_DEPTH) begin
         len_in = LEN_W'(HISTORY_DEPTH);
      end else begin
         len_in = LEN_W'(window_length);
      end
   end

   always_comb begin
      idx_cur = (LEN_W'(widx_ff[chi]) >= len_ff) ? '0 : widx_ff[chi];
      idx_inc = LEN_W'(idx_ff) + LEN_W'(1);
      idx_in  = (idx_inc >= len_ff) ? '0 : IDX_W'(idx_inc);
      sum_in  = sum_ff[chi] - SUM_W'(rd_data) + SUM_W'(smp_ff);
      avg     = (quotient > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : quotient[SAMPLE_W-1:0];
      diff    = (avg >= held_ff[chi]) ? avg - held_ff[chi] : held_ff[chi] - avg;
   end

   always_comb begin
      stat.ch_ok      = (32'(ch_ff) < NUM_CHANNELS);
      stat.need_prime = !primed_ff[chi] || (lenu_ff[chi] != len_ff);
      stat.fill_last  = (LEN_W'(fill_ff) == len_ff - LEN_W'(1));
      stat.div_done   = div_done;
   end

   // History RAM ports
   assign wr_en   = cmd.fill || cmd.update;
   assign wr_addr = cmd.fill ? mem_addr(chi, fill_ff) : mem_addr(chi, idx_ff);
   assign rd_addr = mem_addr(chi, idx_cur);

   madf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MEM_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (smp_ff),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   madf_div #(
      .DVD_W (SUM_W),
      .DVS_W (LEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (work_sum_ff),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            sum_ff[c]    <= '0;
            widx_ff[c]   <= '0;
            held_ff[c]   <= '0;
            primed_ff[c] <= 1'b0;
            lenu_ff[c]   <= '0;
         end
      end else begin
         if (cmd.fill && stat.fill_last) begin
            sum_ff[chi]    <= work_sum_ff;
            widx_ff[chi]   <= '0;
            held_ff[chi]   <= smp_ff;
            primed_ff[chi] <= 1'b1;
            lenu_ff[chi]   <= len_ff;
         end
         if (cmd.update) begin
            sum_ff[chi]  <= sum_in;
            widx_ff[chi] <= idx_in;
         end
         if (cmd.compare && (diff > hysteresis)) begin
            held_ff[chi] <= avg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         ch_ff  <= req_channel;
         smp_ff <= req_sample;
         len_ff <= len_in;
      end
      if (cmd.prime_start) begin
         work_sum_ff <= SUM_W'(smp_ff) * SUM_W'(len_ff);
         fill_ff     <= '0;
      end
      if (cmd.fill) begin
         fill_ff <= fill_ff + IDX_W'(1);
      end
      if (cmd.rd_issue) begin
         idx_ff <= idx_cur;
      end
      if (cmd.update) begin
         work_sum_ff <= sum_in;
      end
      if (cmd.out_load) begin
         out_ch_ff   <= ch_ff;
         out_filt_ff <= held_ff[chi];
      end
   end

   assign out_channel  = out_ch_ff;
   assign out_filtered = out_filt_ff;

   `MADF_ASSERT(a_prime_commit, clock, reset, cmd.fill && stat.fill_last |=> primed_ff[chi] && (held_ff[chi] == smp_ff), "priming did not commit")
   `MADF_ASSERT(a_widx_in_window, clock, reset, primed_ff[chi] |-> (LEN_W'(widx_ff[chi]) < lenu_ff[chi]), "write index outside window")

endmodule

/* src/madf_ctrl.sv */
// ----------------------------------------------------------------------------
// madf_ctrl
// Sequencer for one sample: look up, prime or update, divide, deadband.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module madf_ctrl import madf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output madf_cmd_type  cmd,
   input  madf_stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_FILL,
      S_UPD,
      S_DIVGO,
      S_DIV,
      S_CMP,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE:  cmd.latch = req_valid;
         S_LOOK: begin
            if (stat.ch_ok) begin
               cmd.prime_start = stat.need_prime;
               cmd.rd_issue    = !stat.need_prime;
            end
         end
         S_FILL:  cmd.fill      = 1'b1;
         S_UPD:   cmd.update    = 1'b1;
         S_DIVGO: cmd.div_start = 1'b1;
         S_CMP:   cmd.compare   = 1'b1;
         S_DONE:  cmd.out_load  = !rsp_valid_ff || rsp_ready;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               if (!stat.ch_ok) begin
                  state_ff <= S_IDLE;
               end else if (stat.need_prime) begin
                  state_ff <= S_FILL;
               end else begin
                  state_ff <= S_UPD;
               end
            end
            S_FILL: begin
               if (stat.fill_last) begin
                  state_ff <= S_DONE;
               end
            end
            S_UPD:   state_ff <= S_DIVGO;
            S_DIVGO: state_ff <= S_DIV;
            S_DIV: begin
               if (stat.div_done) begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP:   state_ff <= S_DONE;
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `MADF_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE), "result raised outside done step")
   `MADF_ASSERT(a_div_not_instant, clock, reset, cmd.div_start |=> (state_ff == S_DIV) && !stat.div_done, "divider finished too early")

endmodule

/* bench/moving_average_deadband_filter_core_checker.sv */
// ----------------------------------------------------------------------------
// moving_average_deadband_filter_core_checker
// Passive monitor: tracks register writes, predicts the held average for
// every accepted sample word, and compares each result word in order.
// ----------------------------------------------------------------------------
module moving_average_deadband_filter_core_checker import madf_pkg::*; #(
   parameter int HISTORY_DEPTH = 64,
   parameter int NUM_CHANNELS  = 16
) (
   input  logic clock,
   input  logic reset,
   madf_req_if  req_ch,
   madf_rsp_if  rsp_ch,
   madf_csr_if  csr_ch,
   output int   errors,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SUM_W  = SAMPLE_W + $clog2(HISTORY_DEPTH) + 1;
   localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int LEN_W  = $clog2(HISTORY_DEPTH + 1);

   typedef struct packed {
      logic [CHAN_W-1:0]   channel_out;
      logic [SAMPLE_W-1:0] filtered;
   } filter_word_type;

   logic [SAMPLE_W-1:0] window_ring [NUM_CHANNELS][HISTORY_DEPTH];
   logic [SUM_W-1:0]    window_sum  [NUM_CHANNELS];
   logic [SLOT_W-1:0]   next_slot   [NUM_CHANNELS];
   logic [SAMPLE_W-1:0] held        [NUM_CHANNELS];
   logic                is_primed   [NUM_CHANNELS];
   logic [LEN_W-1:0]    len_last    [NUM_CHANNELS];
   logic [WIN_W-1:0]    window_length;
   logic [HYST_W-1:0]   hysteresis;

   filter_word_type held_outputs_q [$];

   // Advance one channel's filter by one sample and return its held value.
   function automatic logic [SAMPLE_W-1:0] filter_sample(int ch, logic [SAMPLE_W-1:0] s);
      int len;
      int slot;
      int avg;
      int diff;
      len = int'(window_length);
      if (len < 1) len = 1;
      if (len > HISTORY_DEPTH) len = HISTORY_DEPTH;
      if (len != int'(len_last[ch])) begin
         window_sum[ch] = '0;
         next_slot[ch]  = '0;
         held[ch]       = '0;
         is_primed[ch]  = 1'b0;
         len_last[ch]   = LEN_W'(len);
      end
      if (!is_primed[ch]) begin
         for (int i = 0; i < len; i++) window_ring[ch][i] = s;
         window_sum[ch] = SUM_W'(int'(s) * len);
         next_slot[ch]  = '0;
         held[ch]       = s;
         is_primed[ch]  = 1'b1;
      end else begin
         slot = int'(next_slot[ch]);
         if (slot >= len) slot = 0;
         window_sum[ch] = window_sum[ch] - window_ring[ch][slot] + s;
         window_ring[ch][slot] = s;
         slot = slot + 1;
         if (slot >= len) slot = 0;
         next_slot[ch] = SLOT_W'(slot);
         avg = int'(window_sum[ch]) / len;
         if (avg > int'(SAMPLE_MAX)) avg = int'(SAMPLE_MAX);
         diff = (avg >= int'(held[ch])) ? avg - int'(held[ch]) : int'(held[ch]) - avg;
         if (diff > int'(hysteresis)) held[ch] = SAMPLE_W'(avg);
      end
      return held[ch];
   endfunction

   always @(posedge clock) begin
      filter_word_type want;
      if (reset) begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            window_sum[ch] = '0;
            next_slot[ch]  = '0;
            held[ch]       = '0;
            is_primed[ch]  = 1'b0;
            len_last[ch]   = '0;
         end
         window_length = WINDOW_RESET;
         hysteresis    = HYST_RESET;
         held_outputs_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_reg_type'(csr_ch.index))
               REG_WINDOW_LENGTH: window_length = csr_ch.data[WIN_W-1:0];
               REG_HYSTERESIS:    hysteresis    = csr_ch.data[HYST_W-1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (held_outputs_q.size() == 0) begin
               $error("result word with no sample pending: channel_out %0d filtered %0d",
                      rsp_ch.channel_out, rsp_ch.filtered);
               errors = errors + 1;
            end else begin
               want = held_outputs_q.pop_front();
               if (rsp_ch.channel_out !== want.channel_out) begin
                  $error("channel_out mismatch: expected %0d, actual %0d",
                         want.channel_out, rsp_ch.channel_out);
                  errors = errors + 1;
               end
               if (rsp_ch.filtered !== want.filtered) begin
                  $error("filtered mismatch: expected %0d, actual %0d",
                         want.filtered, rsp_ch.filtered);
                  errors = errors + 1;
               end
            end
         end
         // Words on channels the block does not build are dropped silently.
         if (req_ch.valid && req_ch.ready && int'(req_ch.channel) < NUM_CHANNELS) begin
            want.channel_out = req_ch.channel;
            want.filtered    = filter_sample(int'(req_ch.channel), req_ch.sample);
            held_outputs_q.push_back(want);
         end
      end
      pending = held_outputs_q.size();
   end

endmodule

/* bench/moving_average_deadband_filter_core_test.sv */
// ----------------------------------------------------------------------------
// moving_average_deadband_filter_core_test
// Drives sample words and register writes into the filter core with random
// gaps and result stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module moving_average_deadband_filter_core_test import madf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HISTORY_DEPTH = 64;
   localparam int NUM_CHANNELS  = 16;
   localparam int PHASES        = 12;
   localparam int WORDS_PER_PHASE = 120;
   // Slowest legal word: longest send gap, a full-depth prime, longest stall.
   // Several times that over every word, plus register writes.
   localparam int CYCLE_LIMIT   = 600_000;
   localparam int DRAIN_CYCLES  = 100;

   logic clock;
   logic reset;
   int   errors;
   int   pending;
   int   cycle_count = 0;

   // Per-phase stimulus shape.
   bit                no_gaps;
   bit                all_channels;
   logic [CHAN_W-1:0] focus [3];
   int                level;
   int                noise;

   madf_req_if req_ch ();
   madf_rsp_if rsp_ch ();
   madf_csr_if csr_ch ();

   moving_average_deadband_filter_core #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .NUM_CHANNELS  (NUM_CHANNELS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   moving_average_deadband_filter_core_checker #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .NUM_CHANNELS  (NUM_CHANNELS)
   ) checker_i (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .csr_ch  (csr_ch),
      .errors  (errors),
      .pending (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("moving_average_deadband_filter_core verification failed");
         $finish;
      end
   end

   // Offer one sample word: hold off for a random gap, then keep valid up
   // until the block takes it. Return on the falling edge after acceptance
   // with valid still high, so a back-to-back word needs no second drive.
   task automatic send_word(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] s);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.channel <= ch;
      req_ch.sample  <= s;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Write one register once the block has drained every result word.
   task automatic write_reg(csr_reg_type r, logic [CSR_DATA_W-1:0] d);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= r;
      csr_ch.data  <= d;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly a noisy level so the window mean wanders near the held value
   // and crosses the deadband; some wide jumps and rail values mixed in.
   function automatic logic [SAMPLE_W-1:0] next_sample();
      int pick;
      int v;
      pick = $urandom_range(0, 99);
      if (pick < 5) level = $urandom_range(0, 4095);
      if (pick < 70) v = level + int'($urandom_range(0, 2 * noise)) - noise;
      else if (pick < 90) v = $urandom_range(0, 4095);
      else v = pick[0] ? 4095 : 0;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return SAMPLE_W'(v);
   endfunction

   function automatic logic [CHAN_W-1:0] next_channel();
      if (all_channels) return CHAN_W'($urandom_range(0, 15));
      return focus[$urandom_range(0, 2)];
   endfunction

   // Result side: stall a random number of cycles before each word, and
   // hold ready high until that word is taken.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = no_gaps ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      logic [WIN_W-1:0]  win;
      logic [HYST_W-1:0] hyst;
      no_gaps        = 1'b0;
      all_channels   = 1'b1;
      level          = 2048;
      noise          = 16;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.channel = '0;
      req_ch.sample  = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = REG_WINDOW_LENGTH;
      csr_ch.data    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words at the reset settings: window 8, deadband 4.
      send_word(4'd0, 12'd0);       // prime at the floor
      send_word(4'd0, 12'hFFF);     // mean jumps well past the deadband
      send_word(4'd15, 12'hFFF);    // prime at the ceiling
      send_word(4'd15, 12'd0);
      send_word(4'd5, 12'd100);
      send_word(4'd5, 12'd120);     // mean moves by 2: hold
      send_word(4'd5, 12'd140);     // mean moves by 7: update
      send_word(4'd0, 12'hFFF);

      // Zero length saturates to one; the length change re-primes.
      write_reg(REG_WINDOW_LENGTH, 12'h000);
      send_word(4'd0, 12'd2048);
      send_word(4'd0, 12'd2053);    // just past the deadband
      send_word(4'd0, 12'd2057);    // exactly on the deadband: hold
      send_word(4'd15, 12'd1);

      // Low byte 255 with the upper data bits set: saturates to full depth.
      write_reg(REG_WINDOW_LENGTH, 12'hFFF);
      write_reg(REG_HYSTERESIS, 12'h000);
      send_word(4'd3, 12'hFFF);
      send_word(4'd3, 12'd0);
      send_word(4'd3, 12'd0);

      // 65 clamps to the same length, so the window carries on without a
      // fresh prime.
      write_reg(REG_WINDOW_LENGTH, 12'h041);
      send_word(4'd3, 12'hFFF);

      // Widest deadband: the held value can never move.
      write_reg(REG_HYSTERESIS, 12'hFFF);
      send_word(4'd3, 12'd0);
      send_word(4'd3, 12'hFFF);

      // Random phases: fresh settings, channel mix and level each time.
      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 6))
            0:       win = 8'd0;
            1:       win = 8'd1;
            2:       win = WIN_W'($urandom_range(2, 8));
            3:       win = WIN_W'($urandom_range(9, 63));
            4:       win = 8'd64;
            5:       win = WIN_W'($urandom_range(65, 255));
            default: win = WIN_W'($urandom_range(2, 16));
         endcase
         case ($urandom_range(0, 4))
            0:       hyst = 12'd0;
            1:       hyst = HYST_W'($urandom_range(1, 8));
            2:       hyst = HYST_W'($urandom_range(9, 100));
            3:       hyst = HYST_W'($urandom_range(0, 4095));
            default: hyst = 12'hFFF;
         endcase
         // Random upper data bits on the length write must be ignored.
         if ($urandom_range(0, 1)) begin
            write_reg(REG_WINDOW_LENGTH, {CSR_DATA_W'($urandom_range(0, 15)) << WIN_W} | win);
            write_reg(REG_HYSTERESIS, hyst);
         end else begin
            write_reg(REG_HYSTERESIS, hyst);
            write_reg(REG_WINDOW_LENGTH, {CSR_DATA_W'($urandom_range(0, 15)) << WIN_W} | win);
         end

         no_gaps      = ($urandom_range(0, 3) == 0);
         all_channels = ($urandom_range(0, 1) == 0);
         for (int i = 0; i < 3; i++) focus[i] = CHAN_W'($urandom_range(0, 15));
         level = $urandom_range(0, 4095);
         noise = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 200);

         for (int n = 0; n < WORDS_PER_PHASE; n++) send_word(next_channel(), next_sample());
         req_ch.valid <= 1'b0;
      end

      // Drain, then give the block time to show any stray result word.
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (errors == 0 && pending == 0) begin
         $display("moving_average_deadband_filter_core verification clean");
      end else begin
         $display("moving_average_deadband_filter_core verification failed");
      end
      $finish;
   end

endmodule
